FILE: hw/rtl/prs_pkg.sv
// Shared types, constants and the ordering function of the periodic release scheduler.
package prs_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned PER_W    = 16;
  localparam int unsigned DUE_W    = 48;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_NEXT  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_NONE    = 2'd0,
    OP_INSERT  = 2'd1,
    OP_REPLACE = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_POP  = 2'd1,
    S_PUSH = 2'd2,
    S_RESP = 2'd3
  } state_e;

  typedef struct packed {
    cmd_e              command;
    logic [ID_W-1:0]   user_id;
    logic [PER_W-1:0]  period;
  } in_t;

  typedef struct packed {
    logic [ID_W-1:0]   next_user;
    status_e           status;
  } out_t;

  // One registration as held by a cell. The table position breaks full ties.
  typedef struct packed {
    logic              vld;
    logic [DUE_W-1:0]  due;
    logic [ID_W-1:0]   id;
    logic [IDX_W-1:0]  idx;
    logic [PER_W-1:0]  per;
  } cell_t;

  typedef struct packed {
    op_e    op;
    cell_t  x;
  } cell_ctrl_t;

  // True when entry a is served before entry b.
  function automatic logic key_less(cell_t a, cell_t b);
    return {a.due, a.id, a.idx} < {b.due, b.id, b.idx};
  endfunction

endpackage

FILE: hw/rtl/prs_cell.sv
// One cell of the sorted chain: holds one registration and shifts with its neighbors.
module prs_cell
  import prs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cell_ctrl_t  ctrl_i,
  input  logic        head_i,
  input  cell_t       left_i,
  input  logic        lt_left_i,
  input  cell_t       right_i,
  input  logic        lt_right_i,
  output cell_t       self_o,
  output logic        lt_o
);

  cell_t ent_q, ent_d;
  logic  lt_own;

  assign lt_own = ent_q.vld && key_less(ent_q, ctrl_i.x);
  assign lt_o   = lt_own;
  assign self_o = ent_q;

  always_comb begin
    ent_d = ent_q;
    case (ctrl_i.op)
      OP_INSERT: begin
        // Entries after the new one move one place toward the tail.
        if (!lt_own) begin
          ent_d = lt_left_i ? ctrl_i.x : left_i;
        end
      end
      OP_REPLACE: begin
        // The head leaves; earlier entries move toward the head around the reinserted one.
        if (lt_right_i) begin
          ent_d = right_i;
        end else if (lt_own || head_i) begin
          ent_d = ctrl_i.x;
        end
      end
      OP_CLEAR: begin
        ent_d.vld = 1'b0;
      end
      default: begin
        ent_d = ent_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end

endmodule

FILE: hw/rtl/periodic_release_scheduler.sv
// Top level: command sequencer, output register and the sorted chain of cells.
// Each item ends in S_RESP, which loads the output register: clear, rejected add and
// empty next go there directly, an add passes S_PUSH first, a next S_POP and S_PUSH.
// One item at a time: the input stalls until S_RESP hands on the result, and the
// head update (saturating add) and the compare-and-shift of the chain run in turn.
// Reset empties the table at once; no clearing pass is needed.
module periodic_release_scheduler
  import prs_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  in_t   in_data_i,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output out_t  out_data_o
);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  cell_t            x_q, x_d;
  op_e              pend_q, pend_d;
  out_t             resp_q, resp_d;
  logic             out_valid_q, out_valid_d;
  out_t             out_data_q, out_data_d;
  cell_ctrl_t       ctrl;

  cell_t            cells [CAPACITY];
  logic             lt    [CAPACITY];

  logic [DUE_W:0]   sum;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign sum = {1'b0, cells[0].due} + {{(DUE_W + 1 - PER_W){1'b0}}, cells[0].per};

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    x_d         = x_q;
    pend_d      = pend_q;
    resp_d      = resp_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    ctrl.op     = OP_NONE;
    ctrl.x      = x_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          resp_d  = '{next_user: '0, status: ST_OK};
          state_d = S_RESP;
          case (in_data_i.command)
            CMD_CLEAR: begin
              ctrl.op = OP_CLEAR;
              count_d = '0;
            end
            CMD_ADD: begin
              if (count_q == CNT_W'(CAPACITY)) begin
                resp_d.status = ST_FULL;
              end else begin
                x_d.vld = 1'b1;
                x_d.due = {{(DUE_W - PER_W){1'b0}}, in_data_i.period};
                x_d.id  = in_data_i.user_id;
                x_d.idx = count_q[IDX_W-1:0];
                x_d.per = in_data_i.period;
                pend_d  = OP_INSERT;
                count_d = count_q + CNT_W'(1);
                state_d = S_PUSH;
              end
            end
            CMD_NEXT: begin
              if (count_q == '0) begin
                resp_d.status = ST_EMPTY;
              end else begin
                state_d = S_POP;
              end
            end
            default: begin
              resp_d.status = ST_OK;
            end
          endcase
        end
      end
      S_POP: begin
        x_d              = cells[0];
        x_d.due          = sum[DUE_W] ? '1 : sum[DUE_W-1:0];
        resp_d.next_user = cells[0].id;
        pend_d           = OP_REPLACE;
        state_d          = S_PUSH;
      end
      S_PUSH: begin
        ctrl.op = pend_q;
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_data_d  = resp_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    pend_q     <= pend_d;
    resp_q     <= resp_d;
    out_data_q <= out_data_d;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_t left_s, right_s;
    logic  lt_left_s, lt_right_s;

    if (i == 0) begin : g_first
      assign left_s    = '0;
      assign lt_left_s = 1'b1;
    end else begin : g_mid_l
      assign left_s    = cells[i-1];
      assign lt_left_s = lt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_s    = '0;
      assign lt_right_s = 1'b0;
    end else begin : g_mid_r
      assign right_s    = cells[i+1];
      assign lt_right_s = lt[i+1];
    end

    prs_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .head_i     (i == 0),
      .left_i     (left_s),
      .lt_left_i  (lt_left_s),
      .right_i    (right_s),
      .lt_right_i (lt_right_s),
      .self_o     (cells[i]),
      .lt_o       (lt[i])
    );
  end

  // Between items the head cell is occupied exactly when the table is not empty.
  a_head_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (cells[0].vld == (count_q != '0)))
    else $error("head cell occupancy disagrees with entry count");

  a_tail_matches_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (cells[CAPACITY-1].vld == (count_q == CNT_W'(CAPACITY))))
    else $error("tail cell occupancy disagrees with full table");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_push_then_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUSH) |=> (state_q == S_RESP))
    else $error("chain update not followed by result");

  a_error_no_user: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_data_q.status != ST_OK)) |-> (out_data_q.next_user == '0))
    else $error("error result carries a user id");

endmodule
